// ===== sv/retransmit_history_ring_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Retransmit history ring assertion macros
// Concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef RETRANSMIT_HISTORY_RING_UNIT_MACROS_SVH
`define RETRANSMIT_HISTORY_RING_UNIT_MACROS_SVH

`ifndef SYNTH
`define RHR_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("rhr assertion failed");
`define RHR_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
	else $error("rhr forbidden condition");
`else
`define RHR_ASSERT(lbl, clk, rstn, prop)
`define RHR_NEVER(lbl, clk, rstn, expr)
`endif

`endif

// ===== sv/rhr_pkg.sv =====
// ----------------------------------------------------------------------------
// Retransmit history ring package
// Shared types, codes and defaults.
// ----------------------------------------------------------------------------
package rhr_pkg;

	localparam int DEPTH_DEF = 32;
	localparam logic [5:0] THR_RST = 6'd25;

	typedef enum logic [1:0] {
		OP_ADD      = 2'd0,
		OP_FIND_SEQ = 2'd1,
		OP_FIND_KEY = 2'd2,
		OP_CONFIRM  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STS_OK        = 2'd0,
		STS_FULL      = 2'd1,
		STS_NOT_FOUND = 2'd2,
		STS_BEYOND    = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [31:0] seq_number;
		logic [31:0] fragment_handle;
		logic [15:0] sender_id;
		logic [31:0] message_index;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle_out;
		logic [31:0] seq_out;
		logic        flush_request;
		logic [5:0]  occupancy;
	} rsp_t;

	typedef struct packed {
		logic [31:0] handle;
		logic [15:0] sender;
		logic [31:0] msg_index;
	} entry_t;

	typedef struct packed {
		logic rot;
		logic we;
	} chain_ctl_t;

endpackage

// ===== sv/rhr_cell.sv =====
// ----------------------------------------------------------------------------
// Retransmit history ring cell
// One ring entry: loads a new entry or takes its neighbor's on rotate.
// ----------------------------------------------------------------------------
module rhr_cell (
	input  logic            clk,
	input  logic            rot,
	input  logic            we,
	input  rhr_pkg::entry_t wdata,
	input  rhr_pkg::entry_t nbr,
	output rhr_pkg::entry_t ent
);

	rhr_pkg::entry_t ent_q;

	always_ff @(posedge clk) begin
		if (we) begin
			ent_q <= wdata;
		end else if (rot) begin
			ent_q <= nbr;
		end
	end

	assign ent = ent_q;

endmodule

// ===== sv/rhr_chain.sv =====
// ----------------------------------------------------------------------------
// Retransmit history ring cell chain
// Row of cells closed into a ring; cell 0 is the read point.
// ----------------------------------------------------------------------------
module rhr_chain #(
	parameter int DEPTH = rhr_pkg::DEPTH_DEF,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  logic                clk,
	input  rhr_pkg::chain_ctl_t ctl,
	input  logic [CW-1:0]       widx,
	input  rhr_pkg::entry_t     wdata,
	output rhr_pkg::entry_t     front
);

	rhr_pkg::entry_t ents [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rhr_cell u_cell (
			.clk   (clk),
			.rot   (ctl.rot),
			.we    (ctl.we && (widx == CW'(i))),
			.wdata (wdata),
			.nbr   (ents[(i + 1) % DEPTH]),
			.ent   (ents[i])
		);
	end

	assign front = ents[0];

endmodule

// ===== sv/retransmit_history_ring_unit.sv =====
// ----------------------------------------------------------------------------
// Retransmit history ring unit
// Ring of sent fragments for retransmission with add, lookup and confirm.
// ----------------------------------------------------------------------------
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+----------
//  request | req_valid | req_stall | req
//  result  | rsp_valid | rsp_stall | rsp
//  config  | cfg_we    | -         | cfg_wdata
//
//  Add and non-shifting confirm: EXEC goes straight to DONE, no rotation.
//  Lookups: EXEC, then SCAN for one full rotation of the cell ring, then DONE.
//  Confirm releasing d entries: EXEC, then SHIFT with one rotation step per entry.
//  No clearing pass after reset; entries are read only while live.
//  A stalled result register blocks completion of the next request only.
// ----------------------------------------------------------------------------
`include "retransmit_history_ring_unit_macros.svh"

module retransmit_history_ring_unit #(
	parameter int DEPTH = rhr_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  rhr_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output rhr_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [5:0]    cfg_wdata
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int AW = $clog2(DEPTH);

	rhr_pkg::state_t     state_q, state_nxt;
	rhr_pkg::req_t       req_q;
	rhr_pkg::rsp_t       res_q, rsp_q;
	rhr_pkg::rsp_t       res_d, rsp_d;
	rhr_pkg::chain_ctl_t ctl;
	rhr_pkg::entry_t     wdata, front;
	logic                rsp_valid_q;
	logic [31:0]         head_q, tail_q;
	logic [CW-1:0]       cnt_q, d_q;
	logic [AW-1:0]       k_q, tgt_q;
	logic [5:0]          thr_q;
	logic                win_q, found_q;
	logic [31:0]         diff, cnt32, back;
	logic                full, flush, in_conf, stale, out_free, publish, hit;
	logic                k_last;

	assign diff     = req_q.seq_number - tail_q;
	assign cnt32    = 32'(cnt_q);
	assign full     = (cnt_q == CW'(DEPTH));
	assign flush    = (cnt32 >= 32'(thr_q));
	assign in_conf  = (diff <= cnt32);
	assign back     = tail_q - req_q.seq_number;
	assign stale    = !back[31];
	assign out_free = !rsp_valid_q || !rsp_stall;
	assign k_last   = (k_q == AW'(DEPTH - 1));

	assign hit = !found_q && (
		(req_q.operation == rhr_pkg::OP_FIND_SEQ && win_q && k_q == tgt_q) ||
		(req_q.operation == rhr_pkg::OP_FIND_KEY && (32'(k_q) < cnt32) &&
		 front.sender == req_q.sender_id && front.msg_index == req_q.message_index));

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rhr_pkg::S_IDLE: begin
				if (req_valid) state_nxt = rhr_pkg::S_EXEC;
			end
			rhr_pkg::S_EXEC: begin
				unique case (req_q.operation)
					rhr_pkg::OP_FIND_SEQ, rhr_pkg::OP_FIND_KEY: state_nxt = rhr_pkg::S_SCAN;
					rhr_pkg::OP_CONFIRM: begin
						if (in_conf && diff != 32'd0) state_nxt = rhr_pkg::S_SHIFT;
						else state_nxt = rhr_pkg::S_DONE;
					end
					default: state_nxt = rhr_pkg::S_DONE;
				endcase
			end
			rhr_pkg::S_SCAN: begin
				if (k_last) state_nxt = rhr_pkg::S_DONE;
			end
			rhr_pkg::S_SHIFT: begin
				if (d_q == CW'(1)) state_nxt = rhr_pkg::S_DONE;
			end
			rhr_pkg::S_DONE: begin
				if (out_free) state_nxt = rhr_pkg::S_IDLE;
			end
			default: state_nxt = rhr_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_stall = (state_q != rhr_pkg::S_IDLE);
		ctl.rot   = (state_q == rhr_pkg::S_SCAN) || (state_q == rhr_pkg::S_SHIFT);
		ctl.we    = (state_q == rhr_pkg::S_EXEC) &&
			(req_q.operation == rhr_pkg::OP_ADD) && !full;
		publish   = (state_q == rhr_pkg::S_DONE) && out_free;
	end

	always_comb begin
		res_d = res_q;
		if (state_q == rhr_pkg::S_EXEC) begin
			res_d = '0;
			unique case (req_q.operation)
				rhr_pkg::OP_ADD: begin
					res_d.status        = full ? rhr_pkg::STS_FULL : rhr_pkg::STS_OK;
					res_d.seq_out       = head_q;
					res_d.flush_request = flush;
				end
				rhr_pkg::OP_FIND_SEQ, rhr_pkg::OP_FIND_KEY: begin
					res_d.status = rhr_pkg::STS_NOT_FOUND;
				end
				default: begin
					res_d.status = (in_conf || stale) ? rhr_pkg::STS_OK
						: rhr_pkg::STS_BEYOND;
				end
			endcase
		end else if (state_q == rhr_pkg::S_SCAN && hit) begin
			res_d.status     = rhr_pkg::STS_OK;
			res_d.handle_out = front.handle;
			res_d.seq_out    = tail_q + 32'(k_q);
		end
	end

	always_comb begin
		rsp_d           = res_q;
		rsp_d.occupancy = 6'(cnt_q);
	end

	assign wdata.handle    = req_q.fragment_handle;
	assign wdata.sender    = req_q.sender_id;
	assign wdata.msg_index = req_q.message_index;

	rhr_chain #(
		.DEPTH (DEPTH),
		.CW    (CW)
	) u_chain (
		.clk   (clk),
		.ctl   (ctl),
		.widx  (cnt_q),
		.wdata (wdata),
		.front (front)
	);

	always_ff @(posedge clk) begin
		if (state_q == rhr_pkg::S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == rhr_pkg::S_EXEC) begin
			win_q   <= (diff < cnt32);
			tgt_q   <= diff[AW-1:0];
			found_q <= 1'b0;
		end else if (state_q == rhr_pkg::S_SCAN && hit) begin
			found_q <= 1'b1;
		end
		res_q <= res_d;
		if (publish) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rhr_pkg::S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			cnt_q       <= '0;
			d_q         <= '0;
			k_q         <= '0;
			thr_q       <= rhr_pkg::THR_RST;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) thr_q <= cfg_wdata;
			if (ctl.we) begin
				head_q <= head_q + 32'd1;
				cnt_q  <= cnt_q + CW'(1);
			end
			if (state_q == rhr_pkg::S_EXEC && req_q.operation == rhr_pkg::OP_CONFIRM &&
			    in_conf && diff != 32'd0) begin
				tail_q <= req_q.seq_number;
				cnt_q  <= cnt_q - diff[CW-1:0];
				d_q    <= diff[CW-1:0];
			end else if (state_q == rhr_pkg::S_SHIFT) begin
				d_q <= d_q - CW'(1);
			end
			if (state_q == rhr_pkg::S_SCAN) begin
				k_q <= k_last ? '0 : k_q + AW'(1);
			end
			if (publish) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`RHR_NEVER(a_cnt_range, clk, arst_n, cnt_q > CW'(DEPTH))
	`RHR_ASSERT(a_window, clk, arst_n, (head_q - tail_q) == 32'(cnt_q))
	`RHR_NEVER(a_shift_zero, clk, arst_n, state_q == rhr_pkg::S_SHIFT && d_q == '0)
	`RHR_ASSERT(a_rsp_src, clk, arst_n, $rose(rsp_valid_q) |-> $past(state_q == rhr_pkg::S_DONE))
	`RHR_ASSERT(a_scan_end, clk, arst_n, (state_q == rhr_pkg::S_SCAN && k_last) |=> (state_q == rhr_pkg::S_DONE && k_q == '0))

endmodule
